// ----- design/msgd_pkg.sv -----
// Shared types, codes and a helper function for the swipe gesture detector.
package msgd_pkg;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_MOTION_X = 2'd0,
        CMD_MOTION_Y = 2'd1,
        CMD_OTHER    = 2'd2,
        CMD_TICK     = 2'd3
    } cmd_t;

    // Gesture direction codes
    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_MOVE_THRESHOLD = 2'd0,
        REG_COOLDOWN_MS    = 2'd1,
        REG_TAP_MS         = 2'd2,
        REG_UNUSED         = 2'd3
    } reg_idx_t;

    localparam int unsigned DELTA_W  = 16;
    localparam int unsigned THRESH_W = 15;
    localparam int unsigned TIME_W   = 16;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned MDATA_W  = 8;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd10;
    localparam logic [TIME_W-1:0]   TIME_MAX     = 16'hFFFF;

    // One accepted input beat
    typedef struct packed {
        cmd_t               command;
        logic [DELTA_W-1:0] delta;
        logic               sync_flag;
    } item_t;

    // One result beat
    typedef struct packed {
        logic consumed;
        logic press_out;
        logic release_out;
        dir_t gesture_dir;
    } result_t;

    // Magnitude of a two's complement value, saturated to 15 bits
    function automatic logic [THRESH_W-1:0] magnitude(input logic [DELTA_W-1:0] v);
        logic [DELTA_W-1:0] neg;
        neg = ~v + 16'd1;
        if (!v[DELTA_W-1]) begin
            return v[THRESH_W-1:0];
        end else if (neg[DELTA_W-1]) begin
            return {THRESH_W{1'b1}};
        end else begin
            return neg[THRESH_W-1:0];
        end
    endfunction

endpackage

// ----- design/msgd_in_stage.sv -----
// Input register stage: captures one beat and holds it until the core takes it.
module msgd_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  msgd_pkg::item_t s_item,
    input  logic           advance,
    output logic           item_valid,
    output msgd_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    msgd_pkg::item_t item_reg;

    // Free when empty or when the held beat moves on this cycle
    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ----- design/msgd_core.sv -----
// Gesture state, configuration registers and the per-beat update logic.
module msgd_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  msgd_pkg::reg_idx_t             cfg_index,
    input  logic [msgd_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           step,
    input  msgd_pkg::item_t                item,
    output msgd_pkg::result_t              result
);

    // Configuration
    logic [msgd_pkg::THRESH_W-1:0] move_threshold_reg;
    logic [msgd_pkg::TIME_W-1:0]   cooldown_ms_reg;
    logic [msgd_pkg::TIME_W-1:0]   tap_ms_reg;

    // Gesture state
    logic [msgd_pkg::DELTA_W-1:0] accum_x_reg, accum_x_next;
    logic [msgd_pkg::DELTA_W-1:0] accum_y_reg, accum_y_next;
    logic [msgd_pkg::TIME_W-1:0]  ticks_reg, ticks_next;
    logic                         ever_trig_reg, ever_trig_next;
    logic                         pending_reg, pending_next;
    msgd_pkg::dir_t               held_dir_reg, held_dir_next;
    logic [msgd_pkg::TIME_W-1:0]  countdown_reg, countdown_next;

    logic [msgd_pkg::DELTA_W-1:0]  sum_x, sum_y;
    logic [msgd_pkg::THRESH_W-1:0] mag_x, mag_y;
    logic                          over, in_cooldown;
    msgd_pkg::dir_t                dir_new;

    // Candidate accumulator values and their magnitudes
    always_comb begin
        sum_x = accum_x_reg;
        sum_y = accum_y_reg;
        if (item.command == msgd_pkg::CMD_MOTION_X) begin
            sum_x = accum_x_reg + item.delta;
        end
        if (item.command == msgd_pkg::CMD_MOTION_Y) begin
            sum_y = accum_y_reg + item.delta;
        end
        mag_x = msgd_pkg::magnitude(sum_x);
        mag_y = msgd_pkg::magnitude(sum_y);
        over  = (mag_x >= move_threshold_reg) || (mag_y >= move_threshold_reg);
        in_cooldown = (cooldown_ms_reg != '0) && ever_trig_reg
                      && (ticks_reg < cooldown_ms_reg);
        // X wins ties; zero X reads as left, zero Y as down
        if (mag_x >= mag_y) begin
            dir_new = (!sum_x[msgd_pkg::DELTA_W-1] && sum_x != '0) ?
                      msgd_pkg::DIR_RIGHT : msgd_pkg::DIR_LEFT;
        end else begin
            dir_new = sum_y[msgd_pkg::DELTA_W-1] ? msgd_pkg::DIR_UP : msgd_pkg::DIR_DOWN;
        end
    end

    // Next state and result
    always_comb begin
        accum_x_next   = accum_x_reg;
        accum_y_next   = accum_y_reg;
        ticks_next     = ticks_reg;
        ever_trig_next = ever_trig_reg;
        pending_next   = pending_reg;
        held_dir_next  = held_dir_reg;
        countdown_next = countdown_reg;
        result         = '{consumed: 1'b0, press_out: 1'b0, release_out: 1'b0,
                           gesture_dir: msgd_pkg::DIR_RIGHT};
        case (item.command)
            msgd_pkg::CMD_TICK: begin
                if (ticks_reg != msgd_pkg::TIME_MAX) begin
                    ticks_next = ticks_reg + 16'd1;
                end
                if (pending_reg) begin
                    if (countdown_reg <= 16'd1) begin
                        countdown_next     = '0;
                        pending_next       = 1'b0;
                        result.release_out = 1'b1;
                        result.gesture_dir = held_dir_reg;
                    end else begin
                        countdown_next = countdown_reg - 16'd1;
                    end
                end
            end
            msgd_pkg::CMD_MOTION_X, msgd_pkg::CMD_MOTION_Y: begin
                result.consumed = 1'b1;
                accum_x_next    = sum_x;
                accum_y_next    = sum_y;
                if (item.sync_flag && over) begin
                    accum_x_next = '0;
                    accum_y_next = '0;
                    if (!in_cooldown) begin
                        ticks_next     = '0;
                        ever_trig_next = 1'b1;
                        if (!pending_reg) begin
                            pending_next       = 1'b1;
                            held_dir_next      = dir_new;
                            countdown_next     = tap_ms_reg;
                            result.press_out   = 1'b1;
                            result.gesture_dir = dir_new;
                        end
                    end
                end
            end
            default: begin
                // other events pass through untouched
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_threshold_reg <= msgd_pkg::THRESH_RESET;
            cooldown_ms_reg    <= '0;
            tap_ms_reg         <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                msgd_pkg::REG_MOVE_THRESHOLD:
                    move_threshold_reg <= cfg_wdata[msgd_pkg::THRESH_W-1:0];
                msgd_pkg::REG_COOLDOWN_MS: cooldown_ms_reg <= cfg_wdata;
                msgd_pkg::REG_TAP_MS:      tap_ms_reg      <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // State registers, updated once per beat taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_x_reg   <= '0;
            accum_y_reg   <= '0;
            ticks_reg     <= '0;
            ever_trig_reg <= 1'b0;
            pending_reg   <= 1'b0;
            held_dir_reg  <= msgd_pkg::DIR_RIGHT;
            countdown_reg <= '0;
        end else if (step) begin
            accum_x_reg   <= accum_x_next;
            accum_y_reg   <= accum_y_next;
            ticks_reg     <= ticks_next;
            ever_trig_reg <= ever_trig_next;
            pending_reg   <= pending_next;
            held_dir_reg  <= held_dir_next;
            countdown_reg <= countdown_next;
        end
    end

    // A press leaves a gesture pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.press_out |=> pending_reg)
        else $error("press did not set pending");

    // A release only ends a pending gesture
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.release_out |-> pending_reg && !pending_next)
        else $error("release without pending gesture");

    // Press and release never share a beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(result.press_out && result.release_out))
        else $error("press and release on one beat");

endmodule

// ----- design/motion_swipe_gesture_detector.sv -----
// Top level of the swipe gesture detector: input stage, core and output register.
//
// Usage:
//   Slave channel s_*: one beat per event. s_tuser carries the command
//   (0 X motion, 1 Y motion, 2 other event, 3 millisecond tick), s_tdata the
//   signed motion delta, s_tlast the end-of-report flag.
//   Master channel m_*: exactly one result beat per input beat, in order.
//   Config port: cfg_wr_en, cfg_index, cfg_wdata; write only while idle.
//     Index 0 move threshold (15 bits), 1 cooldown in ticks, 2 tap time in ticks.
// Path: input register, then output register, which drives m_tvalid.
// Throughput: one beat per cycle while m_tready is high; the whole state update
//   is one pass of add, magnitude and compare logic between the two registers.
// Reset (aresetn low, synchronous): both channels empty, accumulators and
//   timers cleared, threshold 10, cooldown and tap time 0.
// Stall: while m_tready is low the result holds; one more input beat is
//   taken into the input register, after which s_tready drops.
module motion_swipe_gesture_detector (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,  // [15:0] delta
    input  logic [1:0]                     s_tuser,  // [1:0] command
    input  logic                           s_tlast,  // sync_flag
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] consumed, [1] press_out, [2] release_out, [4:3] gesture_dir, [7:5] zero
    output logic [msgd_pkg::MDATA_W-1:0]   m_tdata,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [1:0]                     cfg_index,
    input  logic [msgd_pkg::CFG_W-1:0]     cfg_wdata
);

    msgd_pkg::item_t   s_item, item;
    msgd_pkg::result_t result;
    msgd_pkg::result_t out_reg;
    logic              item_valid;
    logic              advance;
    logic              out_valid_reg, out_valid_next;

    assign s_item = '{command: msgd_pkg::cmd_t'(s_tuser), delta: s_tdata,
                      sync_flag: s_tlast};

    // Held beat moves into the output register when that is free
    assign advance = item_valid && (!out_valid_reg || m_tready);

    msgd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    msgd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (msgd_pkg::reg_idx_t'(cfg_index)),
        .cfg_wdata (cfg_wdata),
        .step      (advance),
        .item      (item),
        .result    (result)
    );

    // Output valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.gesture_dir, out_reg.release_out,
                       out_reg.press_out, out_reg.consumed};

endmodule

// ----- sim/msgd_gesture_checker.sv -----
// Checker for the swipe gesture detector: predicts each result beat and compares it.
`timescale 1ns / 100ps

module msgd_gesture_checker
    import msgd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] delta
    input  logic [1:0]  s_tuser,   // [1:0] command
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [0] consumed, [1] press_out, [2] release_out, [4:3] gesture_dir, [7:5] zero
    input  logic [7:0]  m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          outstanding
);

    localparam int REPORT_MAX = 10;

    // Shadow copy of the registers
    logic [14:0] thresh;
    logic [15:0] cooldown;
    logic [15:0] tap_time;

    // Shadow copy of the gesture state
    logic [15:0] acc_x;
    logic [15:0] acc_y;
    logic [15:0] ticks_since;
    logic        fired_once;
    logic        pending;
    dir_t        held_dir;
    logic [15:0] release_timer;

    result_t     expected_q[$];
    int          mismatches;

    // Absolute value of a two's complement sum, clipped to 15 bits
    function automatic logic [15:0] abs_clip(input logic [15:0] v);
        logic [15:0] neg;
        neg = ~v + 16'd1;
        if (!v[15]) begin
            return v;
        end else if (neg > 16'd32767) begin
            return 16'd32767;
        end else begin
            return neg;
        end
    endfunction

    // Advance the shadow state by one input beat and return the result it causes
    function automatic result_t next_gesture_result(input item_t it);
        result_t     r;
        logic [15:0] mx;
        logic [15:0] my;
        dir_t        d;
        r = '0;
        case (it.command)
            CMD_TICK: begin
                if (ticks_since != 16'hFFFF) begin
                    ticks_since = ticks_since + 16'd1;
                end
                if (pending) begin
                    if (release_timer <= 16'd1) begin
                        release_timer = '0;
                        pending = 1'b0;
                        r.release_out = 1'b1;
                        r.gesture_dir = held_dir;
                    end else begin
                        release_timer = release_timer - 16'd1;
                    end
                end
            end
            CMD_MOTION_X, CMD_MOTION_Y: begin
                r.consumed = 1'b1;
                if (it.command == CMD_MOTION_X) begin
                    acc_x = acc_x + it.delta;
                end else begin
                    acc_y = acc_y + it.delta;
                end
                if (it.sync_flag) begin
                    mx = abs_clip(acc_x);
                    my = abs_clip(acc_y);
                    if (mx >= {1'b0, thresh} || my >= {1'b0, thresh}) begin
                        if (cooldown != 0 && fired_once && ticks_since < cooldown) begin
                            // still cooling down: drop the motion
                            acc_x = '0;
                            acc_y = '0;
                        end else begin
                            // X wins a tie; zero X reads as left
                            if (mx >= my) begin
                                d = (!acc_x[15] && acc_x != 0) ? DIR_RIGHT : DIR_LEFT;
                            end else begin
                                d = acc_y[15] ? DIR_UP : DIR_DOWN;
                            end
                            acc_x = '0;
                            acc_y = '0;
                            ticks_since = '0;
                            fired_once = 1'b1;
                            if (!pending) begin
                                pending = 1'b1;
                                held_dir = d;
                                release_timer = tap_time;
                                r.press_out = 1'b1;
                                r.gesture_dir = d;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    always @(posedge aclk) begin
        result_t exp_r;
        result_t act_r;
        item_t   it;
        if (!aresetn) begin
            thresh        = 15'd10;
            cooldown      = '0;
            tap_time      = '0;
            acc_x         = '0;
            acc_y         = '0;
            ticks_since   = '0;
            fired_once    = 1'b0;
            pending       = 1'b0;
            held_dir      = DIR_RIGHT;
            release_timer = '0;
            mismatches    = 0;
            expected_q.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end else begin
            // register writes
            if (cfg_wr_en) begin
                case (reg_idx_t'(cfg_index))
                    REG_MOVE_THRESHOLD: thresh = cfg_wdata[14:0];
                    REG_COOLDOWN_MS:    cooldown = cfg_wdata;
                    REG_TAP_MS:         tap_time = cfg_wdata;
                    default: begin
                    end
                endcase
            end

            // result beat against the oldest expectation
            if (m_tvalid && m_tready) begin
                act_r.consumed    = m_tdata[0];
                act_r.press_out   = m_tdata[1];
                act_r.release_out = m_tdata[2];
                act_r.gesture_dir = dir_t'(m_tdata[4:3]);
                if (expected_q.size() == 0) begin
                    report($sformatf("unexpected result beat, tdata %b", m_tdata));
                end else begin
                    exp_r = expected_q.pop_front();
                    if (act_r.consumed != exp_r.consumed ||
                        act_r.press_out != exp_r.press_out ||
                        act_r.release_out != exp_r.release_out ||
                        act_r.gesture_dir != exp_r.gesture_dir ||
                        m_tdata[7:5] != 3'b000) begin
                        report($sformatf(
                            "consumed/press/release/dir exp %b/%b/%b/%s got %b/%b/%b/%s pad %b",
                            exp_r.consumed, exp_r.press_out, exp_r.release_out,
                            exp_r.gesture_dir.name(), act_r.consumed, act_r.press_out,
                            act_r.release_out, act_r.gesture_dir.name(), m_tdata[7:5]));
                    end
                end
            end

            // input beat: predict its result
            if (s_tvalid && s_tready) begin
                it.command   = cmd_t'(s_tuser);
                it.delta     = s_tdata;
                it.sync_flag = s_tlast;
                expected_q.push_back(next_gesture_result(it));
            end

            fail_count  <= mismatches;
            outstanding <= expected_q.size();
        end
    end

endmodule

// ----- sim/motion_swipe_gesture_detector_tb.sv -----
// Testbench top for the swipe gesture detector: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module motion_swipe_gesture_detector_tb;
    import msgd_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 29;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    int          fail_count;
    int          outstanding;
    int          cycle_count  = 0;
    int unsigned beats_sent   = 0;
    int unsigned cur_thresh   = 10;
    logic        tx_no_idle   = 1'b0;
    logic        rx_no_idle   = 1'b0;
    logic        rx_hold_req  = 1'b0;

    always #6 aclk = ~aclk;

    motion_swipe_gesture_detector u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    msgd_gesture_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side backpressure, with one long hold-off when requested
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= rx_no_idle ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // One input beat; returns at the edge where it is taken
    task automatic send_item(input cmd_t cmd, input logic [15:0] delta, input logic sync);
        while (!tx_no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 16'($urandom);
            s_tuser  <= 2'($urandom);
            s_tlast  <= 1'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= delta;
        s_tuser  <= cmd;
        s_tlast  <= sync;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [14:0] thr, input logic [15:0] cool,
                              input logic [15:0] tap);
        write_reg(REG_MOVE_THRESHOLD, {1'b0, thr});
        write_reg(REG_COOLDOWN_MS, cool);
        write_reg(REG_TAP_MS, tap);
        cur_thresh = thr;
    endtask

    // Motion amount, mostly scaled around the current threshold
    function automatic logic [15:0] pick_delta();
        int unsigned span;
        int unsigned mag;
        span = cur_thresh * 2 + 4;
        if (span > 32767) span = 32767;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                mag = $urandom_range(0, span);
                return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
            end
            6, 7:    return 16'($urandom);
            8: begin
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
            default: return 16'h0000;
        endcase
    endfunction

    // A report frame of motion beats closed by sync, then a few ticks
    task automatic send_swipe();
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            send_item($urandom_range(0, 1) ? CMD_MOTION_Y : CMD_MOTION_X, pick_delta(),
                      i == n - 1);
        end
        repeat ($urandom_range(0, 4)) send_item(CMD_TICK, 16'($urandom), 1'($urandom));
    endtask

    task automatic run_phase(input int unsigned quota);
        int unsigned start_count;
        start_count = beats_sent;
        while (beats_sent - start_count < quota) begin
            if ($urandom_range(0, 99) < 20) begin
                send_item(cmd_t'($urandom_range(0, 3)), 16'($urandom), 1'($urandom));
            end else begin
                send_swipe();
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset config (threshold 10, no cooldown, no tap delay)
        send_item(CMD_OTHER, 16'hA5C3, 1'b1);
        send_item(CMD_TICK, 16'h5A3C, 1'b1);
        send_item(CMD_MOTION_X, 16'h7FFF, 1'b0);
        send_item(CMD_MOTION_Y, 16'h8000, 1'b1);   // tie with -32768 clipped: right
        send_item(CMD_TICK, 16'h0000, 1'b0);
        send_item(CMD_MOTION_Y, 16'h8000, 1'b1);   // up
        send_item(CMD_MOTION_X, 16'h0014, 1'b1);   // fires while pending: no press
        send_item(CMD_TICK, 16'hFFFF, 1'b0);
        send_item(CMD_MOTION_X, 16'hFFF1, 1'b1);   // left
        send_item(CMD_TICK, 16'h0000, 1'b0);
        send_item(CMD_MOTION_Y, 16'h000C, 1'b1);   // down
        send_item(CMD_MOTION_Y, 16'h0009, 1'b0);
        send_item(CMD_MOTION_X, 16'h0009, 1'b1);   // just below threshold
        send_item(CMD_TICK, 16'h0000, 1'b0);
        send_item(CMD_MOTION_X, 16'h0001, 1'b1);   // reaches threshold: right
        send_item(CMD_TICK, 16'h0000, 1'b0);
        wait_idle();

        // Directed: zero threshold, short cooldown and tap
        write_reg(REG_UNUSED, 16'hFFFF);
        set_config(15'd0, 16'd2, 16'd1);
        send_item(CMD_MOTION_Y, 16'h0000, 1'b1);   // all zero, still inside cooldown: no press
        send_item(CMD_MOTION_X, 16'h0000, 1'b1);   // inside cooldown
        send_item(CMD_TICK, 16'h0000, 1'b0);
        send_item(CMD_MOTION_X, 16'h0005, 1'b1);   // past cooldown: right
        send_item(CMD_TICK, 16'h0000, 1'b0);
        send_item(CMD_MOTION_Y, 16'h0003, 1'b1);   // inside cooldown again: no press
        send_item(CMD_TICK, 16'h0000, 1'b0);
        send_item(CMD_TICK, 16'h0000, 1'b0);
        wait_idle();

        // Random phases
        set_config(15'd0, 16'd0, 16'd0);
        run_phase(100);

        set_config(15'h7FFF, 16'hFFFF, 16'hFFFF);
        run_phase(100);

        set_config(15'($urandom_range(1, 60)), 16'($urandom_range(0, 6)),
                   16'($urandom_range(0, 5)));
        rx_hold_req = 1'b1;
        run_phase(100);

        set_config(15'($urandom_range(1000, 32767)), 16'd0, 16'($urandom_range(0, 3)));
        run_phase(100);

        set_config(15'($urandom_range(1, 60)), 16'($urandom_range(0, 6)),
                   16'($urandom_range(0, 5)));
        tx_no_idle = 1'b1;
        rx_no_idle = 1'b1;
        run_phase(100);
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;

        for (int p = 0; p < 3; p++) begin
            set_config(15'($urandom_range(1, 60)), 16'($urandom_range(0, 6)),
                       16'($urandom_range(0, 5)));
            run_phase(100);
        end

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
